// ----- rtl/rotation_matrix_to_quaternion_defines.svh -----
// Assertion macros used by the checker file of the matrix-to-quaternion block.
// Needs only a clock and a reset in scope where the macros are used.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RMQ_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RMQ_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ----- rtl/rmq_pkg.sv -----
// Types and constants of the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int DW = 16;
	localparam int FB = 14;

	typedef struct packed {
		logic signed [DW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	} rmq_in_t;

	typedef struct packed {
		logic signed [DW-1:0] qx, qy, qz, qw;
		logic                 bad_input;
	} rmq_out_t;
endpackage

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter, top level.
// Uses rmq_pkg and rmq_divider.
`timescale 1ns / 1ps
// A matrix beat is taken at every rising edge where start is high. busy is tied low, so a new
// matrix may enter in every cycle. Each result leaves on result with done high for exactly one
// cycle, in order, in the default 16-bit Q1.14 format. The receiver cannot stall and none is
// needed. The pipeline is one input stage (case selection, root argument and the three sums and
// differences), 17 square root stages (one root bit per stage), 34 stages of the three parallel
// quotient dividers (one quotient bit per stage) and one output stage that saturates and places
// the components. The root and divider pipelines set the latency; throughput is one matrix per
// cycle.
module rotation_matrix_to_quaternion
	import rmq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  rmq_in_t  matrix,
	output logic     done,
	output rmq_out_t result
);
	localparam int DATA_WIDTH = DW;
	localparam int FRAC_BITS = FB;
	localparam int AW = DATA_WIDTH + 3;          // root argument, signed
	localparam int XW = AW + FRAC_BITS;          // radicand
	localparam int RW = (XW + 1) / 2;            // root
	localparam int SW = DATA_WIDTH + 2;          // sums and differences
	localparam int NW = SW + FRAC_BITS;          // dividend magnitude
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;
	localparam logic [SW-1:0] MAXV = SW'((64'd1 << (DATA_WIDTH-1)) - 1);

	typedef logic signed [DATA_WIDTH-1:0] d_t;
	typedef logic signed [SW-1:0] s_t;

	assign busy = 1'b0;

	// Stage 1: select the case and form the root argument and the three off-root terms.
	d_t e [9];
	assign e[0] = d_t'(matrix.m11); assign e[1] = d_t'(matrix.m12);
	assign e[2] = d_t'(matrix.m13); assign e[3] = d_t'(matrix.m21);
	assign e[4] = d_t'(matrix.m22); assign e[5] = d_t'(matrix.m23);
	assign e[6] = d_t'(matrix.m31); assign e[7] = d_t'(matrix.m32);
	assign e[8] = d_t'(matrix.m33);

	logic signed [AW-1:0] tr, arg;
	s_t s0, s1, s2;
	logic [1:0] isel;
	logic pos;
	always_comb begin
		logic [1:0] i, j, k;
		logic signed [AW-1:0] dii, djj, dkk;
		tr = AW'(e[0]) + AW'(e[4]) + AW'(e[8]);
		pos = tr > 0;
		i = 2'd0;
		if (e[4] > e[0]) i = 2'd1;
		if (e[8] > (i == 2'd1 ? e[4] : e[0])) i = 2'd2;
		j = (i == 2'd2) ? 2'd0 : i + 2'd1;
		k = (j == 2'd2) ? 2'd0 : j + 2'd1;
		dii = AW'(e[{2'b0, i} * 4]);
		djj = AW'(e[{2'b0, j} * 4]);
		dkk = AW'(e[{2'b0, k} * 4]);
		isel = pos ? 2'd3 : i;
		if (pos) begin
			arg = tr + ONE;
			s0 = SW'(e[7]) - SW'(e[5]);
			s1 = SW'(e[2]) - SW'(e[6]);
			s2 = SW'(e[3]) - SW'(e[1]);
		end else begin
			arg = dii - djj - dkk + ONE;
			s0 = SW'(e[{2'b0, k} * 3 + {2'b0, j}]) - SW'(e[{2'b0, j} * 3 + {2'b0, k}]);
			s1 = SW'(e[{2'b0, j} * 3 + {2'b0, i}]) + SW'(e[{2'b0, i} * 3 + {2'b0, j}]);
			s2 = SW'(e[{2'b0, k} * 3 + {2'b0, i}]) + SW'(e[{2'b0, i} * 3 + {2'b0, k}]);
		end
	end

	logic v_s1, bad_s1;
	logic [XW-1:0] x_s1;
	logic [1:0] i_s1;
	s_t s0_s1, s1_s1, s2_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		bad_s1 <= (arg <= 0);
		x_s1 <= XW'({arg[AW-2:0], {FRAC_BITS{1'b0}}}) & {XW{arg > 0}};
		i_s1 <= isel;
		s0_s1 <= s0; s1_s1 <= s1; s2_s1 <= s2;
	end

	// Integer square root pipeline: one root bit per stage.
	localparam int TGW = 3 + 3 * SW;
	logic [RW:0] rv;
	logic [XW+1:0] rx [RW+1];
	logic [RW-1:0] rr [RW+1];
	logic [TGW-1:0] rt [RW+1];
	always_comb begin
		rv[0] = v_s1;
		rx[0] = (XW+2)'(x_s1);
		rr[0] = '0;
		rt[0] = {bad_s1, i_s1, s0_s1, s1_s1, s2_s1};
	end
	// The radicand is shifted up two bits a stage; the remainder is held in its own register.
	logic [RW+1:0] rem [RW+1];
	assign rem[0] = '0;
	for (genvar g = 0; g < RW; g++) begin : g_rt
		logic [RW+1:0] trial, cur;
		assign cur = {rem[g][RW-1:0], rx[g][2*RW-1 -: 2]};
		assign trial = cur - {rr[g], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[g+1] <= 1'b0;
			else rv[g+1] <= rv[g];
		end
		always_ff @(posedge clk) begin
			rx[g+1] <= {rx[g][XW-1:0], 2'b00};
			rem[g+1] <= trial[RW+1] ? cur : trial;
			rr[g+1] <= {rr[g][RW-2:0], ~trial[RW+1]};
			rt[g+1] <= rt[g];
		end
	end

	// Divide |S| * 2^F + R by 2R; the sign and the root half ride along.
	localparam int DGW = 3 + 3 + DATA_WIDTH;
	logic [RW-1:0] root;
	logic [TGW-1:0] tg;
	s_t ss [3];
	assign root = rr[RW];
	assign tg = rt[RW];
	assign ss[0] = tg[3*SW-1 -: SW];
	assign ss[1] = tg[2*SW-1 -: SW];
	assign ss[2] = tg[SW-1:0];

	logic [RW:0] half;
	logic [DATA_WIDTH-1:0] hsat;
	assign half = ({1'b0, root} + 1'b1) >> 1;
	assign hsat = (half > (RW+1)'(MAXV)) ? DATA_WIDTH'(MAXV) : DATA_WIDTH'(half);

	logic dv [3];
	logic [NW+1:0] quo [3];
	logic [DGW-1:0] dtag;
	for (genvar c = 0; c < 3; c++) begin : g_dv
		logic [SW-1:0] mag;
		logic [NW+1:0] n;
		logic [DGW-1:0] to;
		assign mag = ss[c][SW-1] ? SW'(-ss[c]) : SW'(ss[c]);
		assign n = ((NW+2)'(mag) << FRAC_BITS) + (NW+2)'(root);
		rmq_divider #(.NW(NW+2), .DV(RW+1), .TW(DGW)) u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(rv[RW]),
			.num(n), .den({root, 1'b0}),
			.tag_in({tg[TGW-1 -: 3], ss[0][SW-1], ss[1][SW-1], ss[2][SW-1], hsat}),
			.out_valid(dv[c]), .quo(quo[c]), .tag_out(to)
		);
		if (c == 0) begin : g_tag
			assign dtag = to;
		end
	end

	function automatic d_t sat(input logic neg, input logic [NW+1:0] q);
		if (neg) sat = (q > (NW+2)'(MAXV) + 1'b1) ? d_t'(-(MAXV + 1'b1)) : d_t'(-q);
		else sat = (q > (NW+2)'(MAXV)) ? d_t'(MAXV) : d_t'(q);
	endfunction

	// Final stage: saturate and place each component by the selected case.
	logic v_o;
	rmq_out_t res_o;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o <= 1'b0;
		else v_o <= dv[0];
	end
	always_ff @(posedge clk) begin
		d_t a, b, c, h;
		rmq_out_t r;
		a = sat(dtag[DATA_WIDTH+2], quo[0]);
		b = sat(dtag[DATA_WIDTH+1], quo[1]);
		c = sat(dtag[DATA_WIDTH], quo[2]);
		h = d_t'(dtag[DATA_WIDTH-1:0]);
		r = '0;
		r.bad_input = dtag[DGW-1];
		if (!dtag[DGW-1]) begin
			case (dtag[DGW-2 -: 2])
				2'd3: begin
					r.qx = DW'(a); r.qy = DW'(b); r.qz = DW'(c);
					r.qw = DW'(h);
				end
				2'd0: begin
					r.qx = DW'(h); r.qw = DW'(a); r.qy = DW'(b);
					r.qz = DW'(c);
				end
				2'd1: begin
					r.qy = DW'(h); r.qw = DW'(a); r.qz = DW'(b);
					r.qx = DW'(c);
				end
				default: begin
					r.qz = DW'(h); r.qw = DW'(a); r.qx = DW'(b);
					r.qy = DW'(c);
				end
			endcase
		end
		res_o <= r;
	end

	assign done = v_o;
	assign result = res_o;
endmodule

// ----- rtl/rmq_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rmq_divider #(
	parameter int NW = 48,
	parameter int DV = 24,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DV-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic [NW:0]   v_q;
	logic [NW-1:0] n_q [NW+1];
	logic [DV:0]   r_q [NW+1];
	logic [DV-1:0] d_q [NW+1];
	logic [TW-1:0] t_q [NW+1];

	always_comb begin
		v_q[0] = in_valid;
		n_q[0] = num;
		r_q[0] = '0;
		d_q[0] = den;
		t_q[0] = tag_in;
	end

	for (genvar g = 0; g < NW; g++) begin : g_st
		logic [DV+1:0] sh;
		logic [DV+1:0] df;
		assign sh = {r_q[g], n_q[g][NW-1]};
		assign df = sh - {2'b00, d_q[g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[g+1] <= 1'b0;
			else v_q[g+1] <= v_q[g];
		end
		always_ff @(posedge clk) begin
			n_q[g+1] <= {n_q[g][NW-2:0], ~df[DV+1]};
			r_q[g+1] <= df[DV+1] ? sh[DV:0] : df[DV:0];
			d_q[g+1] <= d_q[g];
			t_q[g+1] <= t_q[g];
		end
	end

	assign out_valid = v_q[NW];
	assign quo = n_q[NW];
	assign tag_out = t_q[NW];
endmodule

// ----- rtl/rmq_checker.sv -----
// Port-level checker for the matrix-to-quaternion block, with its bind.
// Uses rmq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_checker
	import rmq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input rmq_out_t result
);
	// Input stage, root stages, divider stages and output stage.
	localparam int LAT = 2 + (DW + 3 + FB + 1) / 2 + (DW + FB + 4);
	localparam int LAT_M1 = LAT - 1;

	`RMQ_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`RMQ_ASSERT_IMP(a_bad_zero, clk, arst_n, done && result.bad_input,
		result.qx == 0 && result.qy == 0 && result.qz == 0 && result.qw == 0)
	`RMQ_ASSERT_IMP(a_known, clk, arst_n, done, !$isunknown(result.bad_input))
	`RMQ_ASSERT_NXT(a_fixed_latency, clk, arst_n, start && !busy, ##LAT_M1 done)
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the rotation matrix to quaternion converter.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion top level.
`timescale 1ns / 1ps

// Holds the quaternions still owed by the converter, oldest first.
class quat_scoreboard;
	rmq_pkg::rmq_out_t owed_quats[$];
	int unsigned n_err;
	int unsigned n_bad;
	int unsigned n_ok;

	function void note_matrix(rmq_pkg::rmq_out_t q);
		owed_quats.push_back(q);
		if (q.bad_input)
			n_bad++;
	endfunction

	function void check_quat(rmq_pkg::rmq_out_t got);
		rmq_pkg::rmq_out_t want;
		if (owed_quats.size() == 0) begin
			$error("unexpected result beat: %p", got);
			n_err++;
			return;
		end
		want = owed_quats.pop_front();
		if (got.qx !== want.qx) begin
			$error("qx: expected %0d, actual %0d", want.qx, got.qx);
			n_err++;
		end
		if (got.qy !== want.qy) begin
			$error("qy: expected %0d, actual %0d", want.qy, got.qy);
			n_err++;
		end
		if (got.qz !== want.qz) begin
			$error("qz: expected %0d, actual %0d", want.qz, got.qz);
			n_err++;
		end
		if (got.qw !== want.qw) begin
			$error("qw: expected %0d, actual %0d", want.qw, got.qw);
			n_err++;
		end
		if (got.bad_input !== want.bad_input) begin
			$error("bad_input: expected %0b, actual %0b", want.bad_input, got.bad_input);
			n_err++;
		end
		n_ok++;
	endfunction
endclass

module tb_top;
	import rmq_pkg::*;

	// Allow ample slack beyond the depth of the pipeline at the default format.
	localparam int DRAIN_CYCLES = 8 * DW;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	rmq_in_t  matrix;
	logic     done;
	rmq_out_t result;

	int unsigned idle_pct;
	int unsigned n_sent;
	quat_scoreboard sb;

	rotation_matrix_to_quaternion uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.matrix(matrix),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run of every phase.
	initial begin
		#(4 * 400000);
		$display("*** FAILED ***");
		$finish;
	end

	// Integer square root, floor, by the bit-pair method.
	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Clamp a signed value to the 16-bit result range.
	function automatic logic signed [DW-1:0] clamp_q(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[DW-1:0];
	endfunction

	// Quotient s * 2^FB / (2 * root), rounded to nearest with ties away from zero.
	function automatic logic signed [DW-1:0] ratio_q(longint s, longint unsigned root);
		longint unsigned mag;
		longint unsigned q;
		mag = (s < 0) ? longint'(-s) : longint'(s);
		q = ((mag << FB) + root) / (root * 2);
		return clamp_q((s < 0) ? -longint'(q) : longint'(q));
	endfunction

	// Expected quaternion for one matrix.
	function automatic rmq_out_t matrix_to_quat(rmq_in_t a);
		longint m[3][3];
		longint tr;
		longint arg;
		longint unsigned root;
		logic signed [DW-1:0] q[4];
		int i;
		int j;
		int k;
		rmq_out_t o;
		m[0][0] = a.m11; m[0][1] = a.m12; m[0][2] = a.m13;
		m[1][0] = a.m21; m[1][1] = a.m22; m[1][2] = a.m23;
		m[2][0] = a.m31; m[2][1] = a.m32; m[2][2] = a.m33;
		o = '0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			root = floor_root(longint'(tr + (64'sd1 << FB)) << FB);
			q[3] = clamp_q(longint'((root + 1) >> 1));
			q[0] = ratio_q(m[2][1] - m[1][2], root);
			q[1] = ratio_q(m[0][2] - m[2][0], root);
			q[2] = ratio_q(m[1][0] - m[0][1], root);
		end else begin
			// Largest diagonal; a later entry must be strictly greater to win.
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			arg = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FB);
			if (arg <= 0) begin
				o.bad_input = 1'b1;
				return o;
			end
			root = floor_root(longint'(arg) << FB);
			q[i] = clamp_q(longint'((root + 1) >> 1));
			q[3] = ratio_q(m[k][j] - m[j][k], root);
			q[j] = ratio_q(m[j][i] + m[i][j], root);
			q[k] = ratio_q(m[k][i] + m[i][k], root);
		end
		o.qx = q[0];
		o.qy = q[1];
		o.qz = q[2];
		o.qw = q[3];
		return o;
	endfunction

	// Result beats cannot be held off, so every done cycle is checked.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_quat(result);
	end

	// Present one matrix and keep it until a rising edge accepts it.
	task automatic send_matrix(rmq_in_t a);
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		matrix <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_matrix(matrix_to_quat(a));
		n_sent++;
		@(negedge clk);
	endtask

	// Wait until the converter owes nothing.
	task automatic drain_all();
		start <= 1'b0;
		while (sb.owed_quats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// An entry of random magnitude class: extremes, near one, or anything.
	function automatic logic signed [DW-1:0] rand_entry();
		case ($urandom_range(5, 0))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return DW'($urandom_range(16384 + 64, 16384 - 64));
			3: return -$signed(DW'($urandom_range(16384 + 64, 16384 - 64)));
			default: return DW'($urandom());
		endcase
	endfunction

	// A near-rotation: a signed permutation matrix with small noise, so every
	// branch of the component choice is exercised.
	function automatic rmq_in_t rand_rotation();
		logic signed [DW-1:0] e[9];
		int perm[3];
		int t;
		int s;
		rmq_in_t a;
		perm = '{0, 1, 2};
		for (int n = 2; n > 0; n--) begin
			s = $urandom_range(n, 0);
			t = perm[n];
			perm[n] = perm[s];
			perm[s] = t;
		end
		for (int n = 0; n < 9; n++)
			e[n] = $signed(16'($urandom_range(4000, 0))) - 16'sd2000;
		for (int r = 0; r < 3; r++)
			e[r * 3 + perm[r]] = $urandom_range(1, 0)
				? 16'sd16384 - e[r * 3 + perm[r]] / 16'sd4
				: -16'sd16384 + e[r * 3 + perm[r]] / 16'sd4;
		a = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return a;
	endfunction

	function automatic rmq_in_t rand_matrix();
		rmq_in_t a;
		case ($urandom_range(9, 0))
			0, 1: a = {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
			2, 3: begin
				a = '0;
				a.m11 = rand_entry(); a.m12 = rand_entry(); a.m13 = rand_entry();
				a.m21 = rand_entry(); a.m22 = rand_entry(); a.m23 = rand_entry();
				a.m31 = rand_entry(); a.m32 = rand_entry(); a.m33 = rand_entry();
			end
			default: a = rand_rotation();
		endcase
		return a;
	endfunction

	function automatic rmq_in_t diag_matrix(int d1, int d2, int d3, int off);
		rmq_in_t a;
		a = '0;
		a.m11 = DW'(d1); a.m22 = DW'(d2); a.m33 = DW'(d3);
		a.m12 = DW'(off); a.m13 = DW'(-off); a.m21 = DW'(-off);
		a.m23 = DW'(off); a.m31 = DW'(off); a.m32 = DW'(-off);
		return a;
	endfunction

	initial begin
		rmq_in_t a;
		sb = new();
		n_sent = 0;
		idle_pct = 0;
		start = 1'b0;
		matrix = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: identity, the half-turns about each axis, ties on
		// the diagonal, a zero trace root, non-positive root arguments and
		// the field extremes that drive every component into saturation.
		send_matrix(diag_matrix(16384, 16384, 16384, 0));
		send_matrix(diag_matrix(16384, -16384, -16384, 0));
		send_matrix(diag_matrix(-16384, 16384, -16384, 0));
		send_matrix(diag_matrix(-16384, -16384, 16384, 0));
		send_matrix(diag_matrix(-16384, -16384, -16384, 0));
		send_matrix(diag_matrix(0, 0, 0, 0));
		send_matrix(diag_matrix(-8192, -8192, -8192, 3000));
		send_matrix(diag_matrix(-16384, -16384, -16384, 1000));
		send_matrix(diag_matrix(100, 100, -200, 700));
		send_matrix(diag_matrix(1, 0, 0, 0));
		send_matrix(diag_matrix(-5, -5, -6, 20000));
		send_matrix(diag_matrix(32767, 32767, 32767, 32767));
		send_matrix(diag_matrix(32767, 32767, 32767, -32768));
		send_matrix(diag_matrix(-32768, -32768, -32768, 32767));
		send_matrix(diag_matrix(-32768, 32767, -32768, -32768));
		send_matrix(diag_matrix(-32768, -32768, 32767, 32767));
		send_matrix(diag_matrix(1, 1, -2, -32768));
		send_matrix(diag_matrix(-10000, -10000, 20000, 0));
		a = '1;
		send_matrix(a);
		a = '0;
		send_matrix(a);
		a = {9{16'sh7fff}};
		send_matrix(a);
		a = {9{16'sh8000}};
		send_matrix(a);

		// Pause with start low until every owed quaternion is back.
		drain_all();

		// Random part in four idling phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 56;
				2: idle_pct = 0;
				default: idle_pct = 10;
			endcase
			repeat (307) send_matrix(rand_matrix());
			if (ph == 1)
				drain_all();
		end

		drain_all();
		$display("Covered %0d matrices, %0d with a non-positive root argument, %0d results checked.",
			n_sent, sb.n_bad, sb.n_ok);
		if (sb.n_err == 0 && sb.owed_quats.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_divider.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
tb/tb_top.sv
